// ----- rtl/ldq_pkg.sv -----
`default_nettype none

package ldq_pkg;

	// Fixed field widths
	localparam int DATA_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;
	localparam int CAP_W     = 5;
	localparam int APB_W     = 32;
	localparam int PADDR_W   = 3;

	// Default store depth and capacity reset value
	localparam int DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Register word index, taken from paddr above the byte offset
	localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

	// Request opcodes
	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_REAR  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_REAR   = 3'd3,
		MODE_LIST       = 3'd4
	} mode_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK           = 2'd0,
		ST_REAR_FULL    = 2'd1,
		ST_FRONT_NOROOM = 2'd2,
		ST_EMPTY        = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic  take;   // request transaction accepted this cycle
		logic  emit;   // result loaded into the output register this cycle
		logic  walk;   // listing entries after the first one
		mode_t op;     // operation in progress (incoming one while idle)
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;      // queue holds no entries
		logic at_rear;    // current list entry is the rear entry
		logic slot_free;  // output register can take a result
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/ldq_req_if.sv -----
`default_nettype none

interface ldq_req_if;
	logic                                valid;
	logic                                ready;
	logic        [ldq_pkg::MODE_W-1:0]   mode;
	logic signed [ldq_pkg::DATA_W-1:0]   push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/ldq_rsp_if.sv -----
`default_nettype none

interface ldq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic        [ldq_pkg::STAT_W-1:0]   status;
	logic signed [ldq_pkg::DATA_W-1:0]   data_value;
	logic                                last_of_run;

	modport source (output valid, output status, output data_value, output last_of_run,
		input ready);
	modport sink   (input valid, input status, input data_value, input last_of_run,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/linear_array_deque.sv -----
// Double-ended queue over a linear array of signed 32-bit words.
// req channel: one transaction per request (mode, push_value); modes are
// push rear, push front, pop front, pop rear and list. Undefined modes are
// accepted and dropped without a result.
// rsp channel: status, data_value and last_of_run; last_of_run marks the
// final result of a request. A list gives one result per entry, front to
// rear, or a single empty-status result on an empty queue.
// Flow: a request is taken while idle and its first result is loaded into
// the output register from the execute state, after the registered store
// read, once that register is free. A list makes one store read per entry.
// One request is in flight at a time.
// A new request may be accepted while the previous result still waits in
// the output register. When the receiver stalls, the controller holds
// its operation until the output register is free.
// Reset empties the queue and sets capacity_in_use to 16; store contents
// are left as they are. capacity_in_use (APB offset 0) is to be written by
// the user only while the block is idle; the block does not enforce this.
`default_nettype none

module linear_array_deque #(
	parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ldq_req_if.sink                            req,
	ldq_rsp_if.source                          rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ldq_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [ldq_pkg::APB_W-1:0]     pwdata,
	output      logic [ldq_pkg::APB_W-1:0]     prdata,
	output      logic                          pready
);

	ldq_pkg::cmd_t cmd;
	ldq_pkg::sts_t sts;
	logic          ctl_ready;

	assign req.ready = ctl_ready;

	// Operation sequencing
	ldq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (ctl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Indices, entry store, output register and configuration
	ldq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.push_value (req.push_value),
		.rsp        (rsp),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

endmodule

`default_nettype wire

// ----- rtl/ldq_ram.sv -----
`default_nettype none

module ldq_ram #(
	parameter int WIDTH = ldq_pkg::DATA_W,
	parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output      logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/ldq_ctrl.sv -----
`default_nettype none

module ldq_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	input  wire logic [ldq_pkg::MODE_W-1:0]   req_mode,
	output      logic                         req_ready,
	input  wire ldq_pkg::sts_t                sts,
	output      ldq_pkg::cmd_t                cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LIST = 3'b100
	} state_t;

	state_t         state_q, state_d;
	ldq_pkg::mode_t op_q;
	logic           legal;

	// Only the five defined opcodes start an operation; others are dropped
	always_comb begin
		unique case (req_mode) inside
			ldq_pkg::MODE_PUSH_REAR, ldq_pkg::MODE_PUSH_FRONT, ldq_pkg::MODE_POP_FRONT,
			ldq_pkg::MODE_POP_REAR, ldq_pkg::MODE_LIST: legal = 1'b1;
			default: legal = 1'b0;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);

	// Commands to the datapath
	always_comb begin
		cmd.take = (state_q == S_IDLE) && req_valid;
		cmd.emit = (state_q != S_IDLE) && sts.slot_free;
		cmd.walk = (state_q == S_LIST);
		cmd.op   = (state_q == S_IDLE) ? ldq_pkg::mode_t'(req_mode) : op_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && legal) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.slot_free) begin
					if (op_q == ldq_pkg::MODE_LIST && !sts.empty && !sts.at_rear) begin
						state_d = S_LIST;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LIST: begin
				if (sts.slot_free && sts.at_rear) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Opcode held for the duration of the operation
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= ldq_pkg::mode_t'(req_mode);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ldq_datapath.sv -----
`default_nettype none

module ldq_datapath #(
	parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ldq_pkg::cmd_t                       cmd,
	output      ldq_pkg::sts_t                       sts,
	input  wire logic signed [ldq_pkg::DATA_W-1:0]   push_value,
	ldq_rsp_if.source                                rsp,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ldq_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [ldq_pkg::APB_W-1:0]           pwdata,
	output      logic [ldq_pkg::APB_W-1:0]           prdata,
	output      logic                                pready
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW    = (ldq_pkg::CAP_W > IDX_W + 1) ? ldq_pkg::CAP_W : IDX_W + 1;

	logic [ldq_pkg::CAP_W-1:0]   cap_q;
	logic [IDX_W-1:0]            front_q, front_d;
	logic [IDX_W-1:0]            rear_q, rear_d;
	logic [IDX_W-1:0]            walk_q, walk_d;
	logic                        empty_q, empty_d;
	logic [ldq_pkg::DATA_W-1:0]  value_q;

	logic                        rsp_valid_q;
	ldq_pkg::status_t            rsp_status_q;
	logic [ldq_pkg::DATA_W-1:0]  rsp_data_q;
	logic                        rsp_last_q;

	ldq_pkg::status_t            res_status;
	logic [ldq_pkg::DATA_W-1:0]  res_data;
	logic                        res_last;

	logic                        we;
	logic [IDX_W-1:0]            waddr;
	logic [IDX_W-1:0]            raddr;
	logic [ldq_pkg::DATA_W-1:0]  rd_data;

	logic [CW-1:0]               cap_ext;
	logic [CW-1:0]               eff_cap;
	logic                        rear_full;
	logic                        at_rear;
	logic                        cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[ldq_pkg::PADDR_W-1:2] == ldq_pkg::REG_CAPACITY);
	assign prdata = (paddr[ldq_pkg::PADDR_W-1:2] == ldq_pkg::REG_CAPACITY) ?
		{{(ldq_pkg::APB_W - ldq_pkg::CAP_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ldq_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[ldq_pkg::CAP_W-1:0];
		end
	end

	// Capacity clamped to 1..DEPTH
	assign cap_ext = CW'(cap_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(DEPTH)) begin
			eff_cap = CW'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign rear_full = (CW'(rear_q) + CW'(1)) >= eff_cap;

	assign at_rear = cmd.walk ? (walk_q == rear_q) : (front_q == rear_q);

	assign sts.empty     = empty_q;
	assign sts.at_rear   = at_rear;
	assign sts.slot_free = !rsp_valid_q || rsp.ready;

	// Operation decode: next indices, store access and result
	always_comb begin
		front_d    = front_q;
		rear_d     = rear_q;
		empty_d    = empty_q;
		walk_d     = walk_q;
		we         = 1'b0;
		waddr      = front_q;
		raddr      = front_q;
		res_status = ldq_pkg::ST_OK;
		res_data   = '0;
		res_last   = 1'b1;
		if (cmd.walk) begin
			// Listing: present the next entry address once this one goes out
			res_data = rd_data;
			res_last = at_rear;
			walk_d   = walk_q + IDX_W'(1);
			raddr    = cmd.emit ? walk_q + IDX_W'(1) : walk_q;
		end else begin
			case (cmd.op)
				ldq_pkg::MODE_PUSH_REAR: begin
					if (empty_q) begin
						front_d = '0;
						rear_d  = '0;
						empty_d = 1'b0;
						we      = 1'b1;
						waddr   = '0;
					end else if (rear_full) begin
						res_status = ldq_pkg::ST_REAR_FULL;
					end else begin
						rear_d = rear_q + IDX_W'(1);
						we     = 1'b1;
						waddr  = rear_q + IDX_W'(1);
					end
				end
				ldq_pkg::MODE_PUSH_FRONT: begin
					if (empty_q || front_q == '0) begin
						res_status = ldq_pkg::ST_FRONT_NOROOM;
					end else begin
						front_d = front_q - IDX_W'(1);
						we      = 1'b1;
						waddr   = front_q - IDX_W'(1);
					end
				end
				ldq_pkg::MODE_POP_FRONT: begin
					if (empty_q) begin
						res_status = ldq_pkg::ST_EMPTY;
					end else begin
						res_data = rd_data;
						if (front_q >= rear_q) begin
							front_d = '0;
							rear_d  = '0;
							empty_d = 1'b1;
						end else begin
							front_d = front_q + IDX_W'(1);
						end
					end
				end
				ldq_pkg::MODE_POP_REAR: begin
					raddr = rear_q;
					if (empty_q) begin
						res_status = ldq_pkg::ST_EMPTY;
					end else begin
						res_data = rd_data;
						if (front_q >= rear_q) begin
							front_d = '0;
							rear_d  = '0;
							empty_d = 1'b1;
						end else begin
							rear_d = rear_q - IDX_W'(1);
						end
					end
				end
				ldq_pkg::MODE_LIST: begin
					raddr = cmd.emit ? front_q + IDX_W'(1) : front_q;
					if (empty_q) begin
						res_status = ldq_pkg::ST_EMPTY;
					end else begin
						res_data = rd_data;
						res_last = at_rear;
						walk_d   = front_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Queue control state, committed when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
			walk_q  <= '0;
		end else if (cmd.emit) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			empty_q <= empty_d;
			walk_q  <= walk_d;
		end
	end

	// Push value captured with the request transaction
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			value_q <= push_value;
		end
	end

	// Entry store
	ldq_ram #(
		.WIDTH (ldq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we && cmd.emit),
		.waddr (waddr),
		.wdata (value_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_status_q <= res_status;
			rsp_data_q   <= res_data;
			rsp_last_q   <= res_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.data_value  = rsp_data_q;
	assign rsp.last_of_run = rsp_last_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_linear_array_deque.sv -----
`timescale 1ns / 100ps

module tb_linear_array_deque;
	import ldq_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DROP_SETTLE = 6;      // covers a dropped request still in flight
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off
	localparam int HOLD_AFTER  = 80;     // results seen before the hold-off starts
	localparam int PHASE_ITEMS = 58;
	localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	// modes the block accepts and drops
	localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

	typedef struct packed {
		status_t            status;
		logic [DATA_W-1:0]  data;
		logic               last;
	} deque_result_t;

	// directed row: optional capacity write first, then one request
	typedef struct packed {
		logic               cfg;
		logic [CAP_W-1:0]   cap;
		logic [MODE_W-1:0]  op;
		logic [DATA_W-1:0]  word;
		logic               typed;
		status_t            t_status;
		logic [DATA_W-1:0]  t_data;
	} deque_row_t;

	localparam int NUM_ROWS = 27;

	deque_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{1'b0, 5'd0, MODE_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY,        32'h0},
		'{1'b0, 5'd0, MODE_POP_REAR,   32'h0000_0000, 1'b1, ST_EMPTY,        32'h0},
		'{1'b0, 5'd0, MODE_LIST,       32'h0000_0000, 1'b1, ST_EMPTY,        32'h0},
		'{1'b0, 5'd0, MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_FRONT_NOROOM, 32'h0},
		'{1'b0, 5'd0, MODE_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_FRONT, 32'h0001_2345, 1'b1, ST_FRONT_NOROOM, 32'h0},
		'{1'b0, 5'd0, MODE_PUSH_REAR,  32'h8000_0000, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_REAR,  32'h0000_0000, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_LIST,       32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,           32'h7FFF_FFFF},
		'{1'b0, 5'd0, MODE_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,           32'h8000_0000},
		'{1'b0, 5'd0, MODE_PUSH_FRONT, 32'h5555_5555, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_FRONT_NOROOM, 32'h0},
		'{1'b0, 5'd0, MODE_RSVD_5,     32'hFFFF_FFFF, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_POP_REAR,   32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_RSVD_7,     32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_LIST,       32'h0000_0000, 1'b0, ST_OK,           32'h0},
		// capacity 0 acts as 1, below the current rear
		'{1'b1, 5'd0, MODE_PUSH_REAR,  32'h0000_0003, 1'b1, ST_REAR_FULL,    32'h0},
		'{1'b0, 5'd0, MODE_POP_REAR,   32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_POP_REAR,   32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_REAR,  32'h0000_0009, 1'b1, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_PUSH_REAR,  32'h0000_000A, 1'b1, ST_REAR_FULL,    32'h0},
		'{1'b0, 5'd0, MODE_RSVD_6,     32'h0000_0000, 1'b0, ST_OK,           32'h0},
		'{1'b0, 5'd0, MODE_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,           32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;

	ldq_req_if req_ch ();
	ldq_rsp_if rsp_ch ();

	linear_array_deque u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the deque state
	logic [DATA_W-1:0] mirror_store [0:SLOTS-1];
	int                mirror_front;
	int                mirror_rear;
	bit                mirror_empty;
	logic [CAP_W-1:0]  mirror_cap;

	deque_result_t deque_results [$];

	int failures     = 0;
	int results_seen = 0;
	int requests     = 0;
	int cycles       = 0;
	int src_calm     = 0;
	int sink_calm    = 0;
	int sink_gap     = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void add_result(status_t st, logic [DATA_W-1:0] data, logic last);
		deque_result_t r;
		r.status = st;
		r.data   = data;
		r.last   = last;
		deque_results.push_back(r);
	endfunction

	// work out the results of one accepted request and update the mirror
	function automatic void step_deque(logic [MODE_W-1:0] op, logic [DATA_W-1:0] word);
		int eff;
		eff = (mirror_cap == 0) ? 1 : (mirror_cap > SLOTS) ? SLOTS : int'(mirror_cap);
		case (op)
			MODE_PUSH_REAR: begin
				if (mirror_empty) begin
					mirror_front = 0;
					mirror_rear  = 0;
					mirror_empty = 1'b0;
					mirror_store[0] = word;
					add_result(ST_OK, '0, 1'b1);
				end else if (mirror_rear + 1 >= eff) begin
					add_result(ST_REAR_FULL, '0, 1'b1);
				end else begin
					mirror_rear++;
					mirror_store[mirror_rear] = word;
					add_result(ST_OK, '0, 1'b1);
				end
			end
			MODE_PUSH_FRONT: begin
				if (mirror_empty || mirror_front == 0) begin
					add_result(ST_FRONT_NOROOM, '0, 1'b1);
				end else begin
					mirror_front--;
					mirror_store[mirror_front] = word;
					add_result(ST_OK, '0, 1'b1);
				end
			end
			MODE_POP_FRONT, MODE_POP_REAR: begin
				if (mirror_empty) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					add_result(ST_OK, mirror_store[(op == MODE_POP_FRONT) ?
						mirror_front : mirror_rear], 1'b1);
					if (mirror_front >= mirror_rear) begin
						mirror_empty = 1'b1;
						mirror_front = 0;
						mirror_rear  = 0;
					end else if (op == MODE_POP_FRONT) begin
						mirror_front++;
					end else begin
						mirror_rear--;
					end
				end
			end
			MODE_LIST: begin
				if (mirror_empty) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = mirror_front; i <= mirror_rear && i < SLOTS; i++)
						add_result(ST_OK, mirror_store[i], i == mirror_rear);
				end
			end
			default: ;  // reserved modes give nothing
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// offer one request, with a random gap ahead of it
	task automatic issue(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] word);
		int gap;
		int r;
		gap = 0;
		if (src_calm > 0) begin
			src_calm--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 2)
				src_calm = $urandom_range(30, 80);
			else if (r < 30)
				gap = $urandom_range(1, 3);
			else if (r < 33)
				gap = $urandom_range(12, 30);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= op;
		req_ch.push_value <= word;
		do @(posedge clk); while (!req_ch.ready);
		step_deque(op, word);
		if (op <= MODE_LIST)
			requests++;
	endtask

	// write capacity while idle, then read it back
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		req_ch.valid <= 1'b0;
		while (deque_results.size() != 0) @(posedge clk);
		repeat (DROP_SETTLE) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAP_ADDR;
		pwdata  <= APB_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mirror_cap = cap;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_W'(cap)) begin
			$display("%0t: capacity readback expected %0d, got %0d", $time, cap, prdata);
			failures++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// response sink: random stalls, calm stretches, one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (sink_calm > 0) begin
			sink_calm--;
			rsp_ch.ready <= 1'b1;
		end else if (sink_gap > 0) begin
			sink_gap--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:2]: begin
					sink_calm = $urandom_range(40, 120);
					rsp_ch.ready <= 1'b1;
				end
				[3:24]: begin
					sink_gap = $urandom_range(0, 2);
					rsp_ch.ready <= 1'b0;
				end
				[25:26]: begin
					sink_gap = $urandom_range(10, 30);
					rsp_ch.ready <= 1'b0;
				end
				default: rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	// compare each result transaction with the oldest one predicted
	always @(posedge clk) begin : check_results
		deque_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (deque_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%0d last=%0d", $time,
					rsp_ch.status, rsp_ch.data_value, rsp_ch.last_of_run);
				failures++;
			end else begin
				want = deque_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.data_value !== want.data ||
					rsp_ch.last_of_run !== want.last) begin
					$display("%0t: expected status=%0d data=%0d last=%0d, got status=%0d data=%0d last=%0d",
						$time, want.status, $signed(want.data), want.last,
						rsp_ch.status, rsp_ch.data_value, rsp_ch.last_of_run);
					failures++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run did not finish within the cycle limit", $time);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CAP_W-1:0] phase_cap [0:5];
		int target;
		int n;
		int k;

		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = '0;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			mirror_store[i] = '0;
		mirror_front = 0;
		mirror_rear  = 0;
		mirror_empty = 1'b1;
		mirror_cap   = CAP_RESET;
		phase_cap    = '{5'd31, 5'd2, 5'd16, 5'd1, 5'd9, 5'd0};
		phase_cap[5] = $urandom_range(0, 31);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int row = 0; row < NUM_ROWS; row++) begin
			if (directed_rows[row].cfg)
				write_capacity(directed_rows[row].cap);
			issue(directed_rows[row].op, directed_rows[row].word);
			if (directed_rows[row].typed) begin
				deque_results[deque_results.size()-1].status = directed_rows[row].t_status;
				deque_results[deque_results.size()-1].data   = directed_rows[row].t_data;
				deque_results[deque_results.size()-1].last   = 1'b1;
			end
		end

		// random phases, one capacity setting each
		for (int p = 0; p < 6; p++) begin
			write_capacity(phase_cap[p]);
			target = requests + PHASE_ITEMS;
			while (requests < target) begin
				case ($urandom_range(0, 99)) inside
					[0:29]: begin
						// fill from the rear
						n = $urandom_range(1, 16);
						repeat (n) issue(MODE_PUSH_REAR, pick_word());
					end
					[30:44]: begin
						// open room at the front, then refill it
						k = $urandom_range(1, 4);
						repeat (k) issue(MODE_POP_FRONT, pick_word());
						repeat (k) issue(MODE_PUSH_FRONT, pick_word());
					end
					[45:59]: begin
						n = $urandom_range(1, 8);
						repeat (n) issue($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR,
							pick_word());
					end
					[60:71]: issue(MODE_LIST, pick_word());
					[72:81]: begin
						issue(MODE_PUSH_REAR, pick_word());
						issue(MODE_LIST, pick_word());
					end
					default: begin
						// noise over all mode codes
						n = $urandom_range(1, 3);
						repeat (n) issue(MODE_W'($urandom_range(0, 7)), $urandom());
					end
				endcase
			end
		end

		req_ch.valid <= 1'b0;
		while (deque_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ldq_pkg.sv
rtl/ldq_req_if.sv
rtl/ldq_rsp_if.sv
rtl/ldq_ram.sv
rtl/ldq_ctrl.sv
rtl/ldq_datapath.sv
rtl/linear_array_deque.sv
tb/sv/tb_linear_array_deque.sv
